// ===== rtl/ipv6_pseudo_header_checksum_assert.svh =====
// Assertion macros for the pseudo-header checksum block.
// Each checks an implication, sampled at the rising clock edge, with reset masking.
`ifndef IPV6_PSEUDO_HEADER_CHECKSUM_ASSERT_SVH
`define IPV6_PSEUDO_HEADER_CHECKSUM_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define IPV6PHC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ipv6 checksum: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define IPV6PHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipv6 checksum: next-cycle check failed");

`else

`define IPV6PHC_ASSERT_SAME(label, clk, rst, ante, cons)
`define IPV6PHC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/ipv6ck_pkg.sv =====
`default_nettype none

package ipv6ck_pkg;

   // Kind of item carried on the input stream
   localparam logic FUNC_ADDR = 1'b0;
   localparam logic FUNC_DATA = 1'b1;

   // Data byte counts
   localparam logic [1:0] BYTES_NONE = 2'd0;
   localparam logic [1:0] BYTES_ONE  = 2'd1;

   // Word positions inside one address
   localparam logic [2:0] ADDR_POS_SCOPE = 3'd0;
   localparam logic [2:0] ADDR_POS_EMBED = 3'd1;

   // Link-local scope patterns on the first word of an address
   localparam logic [15:0] LL_UCAST_MASK = 16'hffc0;
   localparam logic [15:0] LL_UCAST      = 16'hfe80;
   localparam logic [15:0] LL_MCAST_MASK = 16'hff0f;
   localparam logic [15:0] LL_MCAST      = 16'hff02;

   typedef logic [4:0] addr_idx_type;

   // State of a packet at its last beat, handed to the finishing stage
   typedef struct packed {
      logic [15:0] sum;
      logic        pend_valid;
      logic [7:0]  pend_byte;
      logic [31:0] total;
      logic [7:0]  next_header;
   } pkt_end_type;

   // Ones-complement add with end-around carry; the result never exceeds 16'hffff
   function automatic logic [15:0] add_fold(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic logic is_link_scope(input logic [15:0] w);
      return ((w & LL_UCAST_MASK) == LL_UCAST) || ((w & LL_MCAST_MASK) == LL_MCAST);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ipv6_pseudo_header_checksum.sv =====
// A packet's last beat is registered in the finishing stage, then its result in the output register.
// Throughput: one input beat per cycle unless stalled; the running sum takes one ones-complement add
// per beat, and the pseudo-header terms are added in a separate stage after the last beat.
// Stalls: input is held only while a finished packet waits behind a result that is not taken.
// Reset: synchronous, active high; clears the running state and empties both stages.
`default_nettype none

module ipv6_pseudo_header_checksum
   import ipv6ck_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // word[15:0], byte_count[17:16], next_header[25:18]
   input  wire logic [0:0]  req_tuser,   // func[0]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // checksum[15:0], segment_length[47:16]
);

   logic        beat_en;
   pkt_end_type pkt_end;
   logic        pkt_done;

   pkt_end_type fin_ff;
   logic        fin_valid_ff, fin_valid_in;
   logic        fin_adv;
   logic        fin_stall;
   logic        out_free;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] cksum_ff;
   logic [31:0] seglen_ff;

   logic [18:0] wide_sum;
   logic [16:0] fold1;
   logic [15:0] fold2;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fin_adv    = fin_valid_ff && out_free;
   assign fin_stall  = fin_valid_ff && !out_free;
   assign req_tready = !fin_valid_ff || out_free;
   assign beat_en    = req_tvalid && req_tready;

   ipv6ck_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .beat_en     (beat_en),
      .func        (req_tuser[0]),
      .word        (req_tdata[15:0]),
      .byte_count  (req_tdata[17:16]),
      .next_header (req_tdata[25:18]),
      .last        (req_tlast),
      .pkt_end     (pkt_end),
      .pkt_done    (pkt_done)
   );

   // Pseudo-header terms: padded odd byte, length high and low, next header
   always_comb begin
      wide_sum = 19'(fin_ff.sum)
               + (fin_ff.pend_valid ? 19'({fin_ff.pend_byte, 8'd0}) : 19'd0)
               + 19'(fin_ff.total[31:16])
               + 19'(fin_ff.total[15:0])
               + 19'(fin_ff.next_header);
      fold1 = 17'(wide_sum[15:0]) + 17'(wide_sum[18:16]);
      fold2 = fold1[15:0] + 16'(fold1[16]);
   end

   assign fin_valid_in = pkt_done || fin_stall;
   assign rsp_valid_in = fin_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pkt_done) begin
         fin_ff <= pkt_end;
      end
      if (fin_adv) begin
         cksum_ff  <= ~fold2;
         seglen_ff <= fin_ff.total;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {seglen_ff, cksum_ff};

`include "ipv6_pseudo_header_checksum_assert.svh"

   `IPV6PHC_ASSERT_NEXT(a_last_fills_fin, clock, reset, beat_en && req_tlast, fin_valid_ff)
   `IPV6PHC_ASSERT_NEXT(a_fin_held, clock, reset, fin_stall, fin_valid_ff && $stable(fin_ff))
   `IPV6PHC_ASSERT_NEXT(a_fin_moves_out, clock, reset, fin_adv, rsp_valid_ff)
   `IPV6PHC_ASSERT_SAME(a_full_stalls_input, clock, reset, fin_stall, !req_tready)

endmodule

`default_nettype wire

// ===== rtl/ipv6ck_accum.sv =====
`default_nettype none

module ipv6ck_accum
   import ipv6ck_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        beat_en,
   input  wire logic        func,
   input  wire logic [15:0] word,
   input  wire logic [1:0]  byte_count,
   input  wire logic [7:0]  next_header,
   input  wire logic        last,
   output pkt_end_type      pkt_end,
   output logic             pkt_done
);

   logic [15:0]  sum_ff,   sum_in;
   logic [7:0]   pb_ff,    pb_in;
   logic         pv_ff,    pv_in;
   addr_idx_type idx_ff,   idx_in;
   logic         scope_ff, scope_in;
   logic [31:0]  total_ff, total_in;

   logic         add_en;
   logic [15:0]  addend;

   always_comb begin
      add_en   = 1'b0;
      addend   = word;
      idx_in   = idx_ff;
      scope_in = scope_ff;
      pv_in    = pv_ff;
      pb_in    = pb_ff;
      total_in = total_ff;
      if (func == FUNC_ADDR) begin
         // address words past the destination are dropped
         if (!idx_ff[4]) begin
            idx_in = idx_ff + addr_idx_type'(1);
            if (idx_ff[2:0] == ADDR_POS_SCOPE) begin
               scope_in = is_link_scope(word);
               add_en   = 1'b1;
            end else if (!(idx_ff[2:0] == ADDR_POS_EMBED && scope_ff)) begin
               add_en = 1'b1;
            end
         end
      end else begin
         case (byte_count)
            BYTES_NONE: begin
            end
            BYTES_ONE: begin
               total_in = total_ff + 32'd1;
               if (pv_ff) begin
                  add_en = 1'b1;
                  addend = {pb_ff, word[15:8]};
                  pv_in  = 1'b0;
                  pb_in  = 8'd0;
               end else begin
                  pb_in = word[15:8];
                  pv_in = 1'b1;
               end
            end
            default: begin
               total_in = total_ff + 32'd2;
               add_en   = 1'b1;
               if (pv_ff) begin
                  // pair the held byte with the upper byte, hold the lower one
                  addend = {pb_ff, word[15:8]};
                  pb_in  = word[7:0];
               end else begin
                  pv_in = 1'b0;
                  pb_in = 8'd0;
               end
            end
         endcase
      end
      sum_in = add_en ? add_fold(sum_ff, addend) : sum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (beat_en && last)) begin
         sum_ff   <= '0;
         pb_ff    <= '0;
         pv_ff    <= 1'b0;
         idx_ff   <= '0;
         scope_ff <= 1'b0;
         total_ff <= '0;
      end else if (beat_en) begin
         sum_ff   <= sum_in;
         pb_ff    <= pb_in;
         pv_ff    <= pv_in;
         idx_ff   <= idx_in;
         scope_ff <= scope_in;
         total_ff <= total_in;
      end
   end

   assign pkt_done = beat_en && last;
   assign pkt_end  = '{sum: sum_in, pend_valid: pv_in, pend_byte: pb_in,
                       total: total_in, next_header: next_header};

endmodule

`default_nettype wire

// ===== test/ipv6_pseudo_header_checksum_checker.sv =====
module ipv6_pseudo_header_checksum_checker
   import ipv6ck_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,   // word[15:0], byte_count[17:16], next_header[25:18]
   input  wire logic [0:0]  req_tuser,   // func[0]
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,   // checksum[15:0], segment_length[47:16]
   output int               fail_count,
   output int               open_results
);

   localparam logic [4:0] ADDR_WORDS = 5'd16;

   typedef struct packed {
      logic [15:0] checksum;
      logic [31:0] seg_len;
   } csum_result_type;

   csum_result_type expected_sums[$];

   logic [31:0] sum_acc;
   logic [7:0]  odd_byte;
   logic        odd_valid;
   logic [4:0]  addr_idx;
   logic        skip_embed;
   logic [31:0] seg_bytes;
   int          errors = 0;

   function automatic logic [31:0] fold_carry(input logic [31:0] s);
      logic [31:0] t;
      t = {16'd0, s[15:0]} + {16'd0, s[31:16]};
      return {16'd0, t[15:0]} + {16'd0, t[31:16]};
   endfunction

   task automatic add_term(input logic [15:0] w);
      sum_acc = fold_carry(sum_acc + {16'd0, w});
   endtask

   task automatic clear_packet();
      sum_acc    = '0;
      odd_byte   = '0;
      odd_valid  = 1'b0;
      addr_idx   = '0;
      skip_embed = 1'b0;
      seg_bytes  = '0;
   endtask

   // Pair bytes across chunks; a lone byte waits for its partner
   task automatic take_octet(input logic [7:0] b);
      if (odd_valid) begin
         add_term({odd_byte, b});
         odd_valid = 1'b0;
         odd_byte  = '0;
      end else begin
         odd_byte  = b;
         odd_valid = 1'b1;
      end
      seg_bytes = seg_bytes + 32'd1;
   endtask

   task automatic predict_checksum(input logic func, input logic [15:0] word,
                                   input logic [1:0] count, input logic [7:0] nh,
                                   input logic eop);
      csum_result_type r;
      if (func == FUNC_ADDR) begin
         if (addr_idx < ADDR_WORDS) begin
            if (addr_idx[2:0] == ADDR_POS_SCOPE) begin
               skip_embed = ((word & LL_UCAST_MASK) == LL_UCAST) ||
                            ((word & LL_MCAST_MASK) == LL_MCAST);
               add_term(word);
            end else if (!(addr_idx[2:0] == ADDR_POS_EMBED && skip_embed)) begin
               add_term(word);
            end
            addr_idx = addr_idx + 5'd1;
         end
      end else begin
         if (count != BYTES_NONE) take_octet(word[15:8]);
         if (count > BYTES_ONE) take_octet(word[7:0]);
      end
      if (eop) begin
         // pad a trailing byte, then fold in length and next header
         if (odd_valid) add_term({odd_byte, 8'h00});
         add_term(seg_bytes[31:16]);
         add_term(seg_bytes[15:0]);
         add_term({8'h00, nh});
         sum_acc = fold_carry(sum_acc);
         r.checksum = ~sum_acc[15:0];
         r.seg_len  = seg_bytes;
         expected_sums.push_back(r);
         clear_packet();
      end
   endtask

   always @(posedge clock) begin : watch
      csum_result_type want;
      if (reset) begin
         clear_packet();
         expected_sums.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected result beat: checksum %h length %0d", $time,
                        rsp_tdata[15:0], rsp_tdata[47:16]);
               errors++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_tdata[15:0] !== want.checksum) begin
                  $display("%0t: checksum mismatch: expected %h actual %h", $time,
                           want.checksum, rsp_tdata[15:0]);
                  errors++;
               end
               if (rsp_tdata[47:16] !== want.seg_len) begin
                  $display("%0t: segment length mismatch: expected %0d actual %0d", $time,
                           want.seg_len, rsp_tdata[47:16]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_checksum(req_tuser[0], req_tdata[15:0], req_tdata[17:16],
                             req_tdata[25:18], req_tlast);
      end
      fail_count   <= errors;
      open_results <= expected_sums.size();
   end

endmodule

// ===== test/ipv6_pseudo_header_checksum_tb.sv =====
module ipv6_pseudo_header_checksum_tb
   import ipv6ck_pkg::*;
();

   localparam logic [1:0] BYTES_TWO   = 2'd2;
   localparam logic [1:0] BYTES_THREE = 2'd3;
   localparam int MAX_IDLE     = 14;
   localparam int HOLD_CYCLES  = 600;
   localparam int RANDOM_BEATS = 450;
   localparam int MIN_PACKETS  = 20;

   typedef struct packed {
      logic        func;
      logic [15:0] word;
      logic [1:0]  count;
      logic [7:0]  nh;
      logic        eop;
   } beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // word[15:0], byte_count[17:16], next_header[25:18]
   logic [0:0]  req_tuser  = '0;   // func[0]
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // checksum[15:0], segment_length[47:16]
   int          fail_count;
   int          open_results;

   beat_type beat_q[$];

   ipv6_pseudo_header_checksum u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   ipv6_pseudo_header_checksum_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .open_results (open_results)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

   task automatic add_beat(input logic func, input logic [15:0] word, input logic [1:0] count,
                           input logic [7:0] nh, input logic eop);
      beat_type b;
      b.func  = func;
      b.word  = word;
      b.count = count;
      b.nh    = nh;
      b.eop   = eop;
      beat_q.push_back(b);
   endtask

   // Draw the idle cycles before the next beat; now and then run a stretch without idling
   task automatic pick_idle(inout int calm, output int cycles);
      if (calm > 0) begin
         calm--;
         cycles = 0;
      end else begin
         cycles = $urandom_range(0, MAX_IDLE);
         if ($urandom_range(0, 19) == 0) calm = $urandom_range(10, 60);
      end
   endtask

   function automatic logic [15:0] scope_word();
      case ($urandom_range(0, 5))
         0, 1:    return LL_UCAST | 16'($urandom_range(0, 63));
         2:       return LL_MCAST | {8'h00, 4'($urandom_range(0, 15)), 4'h0};
         3:       return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] pick_count();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return BYTES_ONE;
         8:          return BYTES_NONE;
         9:          return BYTES_THREE;
         default:    return BYTES_TWO;
      endcase
   endfunction

   task automatic add_addr_words(input int from, input int upto);
      for (int i = from; i < upto; i++) begin
         if (i % 8 == 0)
            add_beat(FUNC_ADDR, scope_word(), pick_count(), 8'($urandom_range(0, 255)), 1'b0);
         else
            add_beat(FUNC_ADDR, 16'($urandom), pick_count(), 8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   task automatic add_data(input int n);
      for (int i = 0; i < n; i++)
         add_beat(FUNC_DATA, 16'($urandom), pick_count(), 8'($urandom_range(0, 255)), 1'b0);
   endtask

   task automatic build_directed();
      logic [15:0] hdr [0:15];
      // zero sum gives all ones; an all-ones sum gives zero
      add_beat(FUNC_ADDR, 16'h0000, BYTES_NONE, 8'h00, 1'b1);
      add_beat(FUNC_DATA, 16'hfffd, BYTES_TWO, 8'h00, 1'b1);
      // lone trailing byte gets padded
      add_beat(FUNC_DATA, 16'hffff, BYTES_ONE, 8'hff, 1'b1);
      // link-local unicast source, link-local multicast destination
      hdr = '{16'hfe80, 16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0001,
              16'hff02, 16'habcd, 16'hffff, 16'h0000, 16'h8000, 16'h7fff, 16'h0000, 16'hffff};
      foreach (hdr[i]) add_beat(FUNC_ADDR, hdr[i], BYTES_TWO, 8'h00, 1'b0);
      add_beat(FUNC_ADDR, 16'hffff, BYTES_TWO, 8'h00, 1'b0);
      add_beat(FUNC_DATA, 16'hab00, BYTES_ONE, 8'h00, 1'b0);
      add_beat(FUNC_DATA, 16'hcdef, BYTES_TWO, 8'h00, 1'b0);
      add_beat(FUNC_DATA, 16'h5555, BYTES_NONE, 8'h00, 1'b0);
      add_beat(FUNC_DATA, 16'h0102, BYTES_THREE, 8'h00, 1'b0);
      add_beat(FUNC_DATA, 16'hff00, BYTES_ONE, 8'd17, 1'b1);
   endtask

   task automatic build_random();
      int first;
      int packets;
      int n;
      first   = beat_q.size();
      packets = 0;
      while ((beat_q.size() - first) < RANDOM_BEATS || packets < MIN_PACKETS) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               add_addr_words(0, 16);
               add_data($urandom_range(0, 12));
            end
            6: begin
               add_addr_words(0, $urandom_range(0, 15));
               add_data($urandom_range(1, 4));
            end
            7: begin
               // destination arrives after some data
               add_addr_words(0, 8);
               add_data($urandom_range(1, 5));
               add_addr_words(8, 16);
               add_data($urandom_range(0, 5));
            end
            8: begin
               add_addr_words(0, 16 + $urandom_range(1, 4));
               add_data($urandom_range(0, 6));
            end
            default: begin
               n = $urandom_range(1, 20);
               for (int i = 0; i < n; i++)
                  add_beat(1'($urandom_range(0, 1)), 16'($urandom), 2'($urandom_range(0, 3)),
                           8'($urandom_range(0, 255)), 1'b0);
            end
         endcase
         beat_q[beat_q.size() - 1].eop = 1'b1;
         packets++;
      end
   endtask

   task automatic send_beats();
      beat_type b;
      int gap;
      int calm;
      calm = 0;
      while (beat_q.size() != 0) begin
         b = beat_q.pop_front();
         pick_idle(calm, gap);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= {6'd0, b.nh, b.count, b.word};
         req_tuser  <= b.func;
         req_tlast  <= b.eop;
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      build_directed();
      build_random();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_beats();
      do @(posedge clock); while (open_results != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && open_results == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin : sink
      int stall;
      int calm;
      int taken;
      logic held;
      calm  = 0;
      taken = 0;
      held  = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && taken == 8) begin
            // hold off long enough for the block to back up into its input
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            pick_idle(calm, stall);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ipv6ck_pkg.sv
rtl/ipv6ck_accum.sv
rtl/ipv6_pseudo_header_checksum.sv
test/ipv6_pseudo_header_checksum_checker.sv
test/ipv6_pseudo_header_checksum_tb.sv
